@@ hdl/ftr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ftr_pkg - shared types and constants of the text rasterizer
// Glyph geometry, pen advances, register indexes, character codes and the
// packed beat types of the input and result channels.
// ----------------------------------------------------------------------------
package ftr_pkg;

  localparam int GLYPH_ROWS    = 7;
  localparam int GLYPH_COLUMNS = 5;
  localparam int ROM_ROWS      = 7;
  localparam int ADVANCE_X     = 6;
  localparam int ADVANCE_Y     = 8;

  localparam int ROW_W = $clog2(GLYPH_ROWS);
  localparam int COL_W = $clog2(GLYPH_COLUMNS);

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_ADDR_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_LINE_PITCH    = 2'd2;

  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;

  typedef struct packed {
    logic               string_start;
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic [7:0]         char_code;
    logic [7:0]         ink_color;
  } ftr_in_t;

  typedef struct packed {
    logic [21:0] pixel_address;
    logic [7:0]  pixel_color;
    logic        last_of_char;
  } ftr_out_t;

endpackage : ftr_pkg
`default_nettype wire

@@ hdl/ftr_glyph_rom.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ftr_glyph_rom - 5x7 font lookup
// Returns the pixel bits of one glyph row for an uppercase-folded code,
// column 0 in the MSB. Unknown codes give the error glyph, space is blank.
// ----------------------------------------------------------------------------
module ftr_glyph_rom (
  input  wire logic [7:0]                      code,
  input  wire logic [ftr_pkg::ROW_W-1:0]       row,
  output logic [ftr_pkg::GLYPH_COLUMNS-1:0]    bits
);
  import ftr_pkg::*;

  logic [55:0] glyph;
  logic [7:0]  row_byte;
  logic [15:0] row_wide;

  // Seven row bytes per glyph, top row in the high byte.
  always_comb begin
    case (code)
      8'h41: glyph = 56'h0E11111F111111;
      8'h42: glyph = 56'h1E11111E11111E;
      8'h43: glyph = 56'h0E11101010110E;
      8'h44: glyph = 56'h1C12111111121C;
      8'h45: glyph = 56'h1F10101E10101F;
      8'h46: glyph = 56'h1F10101E101010;
      8'h47: glyph = 56'h0E11101711110E;
      8'h48: glyph = 56'h1111111F111111;
      8'h49: glyph = 56'h1F04040404041F;
      8'h4A: glyph = 56'h1F02020212120C;
      8'h4B: glyph = 56'h11121418141211;
      8'h4C: glyph = 56'h1010101010101F;
      8'h4D: glyph = 56'h111B1515111111;
      8'h4E: glyph = 56'h11111915131111;
      8'h4F: glyph = 56'h0E11111111110E;
      8'h50: glyph = 56'h1E11111E101010;
      8'h51: glyph = 56'h0E11111115120D;
      8'h52: glyph = 56'h1E11111E141211;
      8'h53: glyph = 56'h0F10100E01011E;
      8'h54: glyph = 56'h1F040404040404;
      8'h55: glyph = 56'h1111111111110E;
      8'h56: glyph = 56'h11111111110A04;
      8'h57: glyph = 56'h11111115151B11;
      8'h58: glyph = 56'h11110A040A1111;
      8'h59: glyph = 56'h11110A04040404;
      8'h5A: glyph = 56'h1F01020408101F;
      8'h30: glyph = 56'h0E11131519110E;
      8'h31: glyph = 56'h040C140404041F;
      8'h32: glyph = 56'h0E11010204081F;
      8'h33: glyph = 56'h1E01010E01011E;
      8'h34: glyph = 56'h02060A121F0202;
      8'h35: glyph = 56'h1F10101E01011E;
      8'h36: glyph = 56'h0E10101E11110E;
      8'h37: glyph = 56'h1F010204080808;
      8'h38: glyph = 56'h0E11110E11110E;
      8'h39: glyph = 56'h0E11110F01010E;
      8'h3E: glyph = 56'h10080402040810;
      8'h3C: glyph = 56'h01020408040201;
      8'h3A: glyph = 56'h00040400040400;
      8'h2D: glyph = 56'h0000001F000000;
      8'h5F: glyph = 56'h0000000000001F;
      8'h2E: glyph = 56'h00000000000C0C;
      8'h2F: glyph = 56'h01020408100000;
      8'h5C: glyph = 56'h10080402010000;
      8'h5B: glyph = 56'h0E08080808080E;
      8'h5D: glyph = 56'h0E02020202020E;
      8'h3D: glyph = 56'h00001F001F0000;
      8'h2B: glyph = 56'h0004041F040400;
      8'h28: glyph = 56'h02040808080402;
      8'h29: glyph = 56'h08040202020408;
      8'h3F: glyph = 56'h0E110102040004;
      8'h21: glyph = 56'h04040404040004;
      CHAR_SPACE: glyph = 56'h0;
      default: glyph = 56'h1F010509110011;
    endcase
  end

  // Rows below the font are blank.
  always_comb begin
    case (row)
      ROW_W'(0): row_byte = glyph[55:48];
      ROW_W'(1): row_byte = glyph[47:40];
      ROW_W'(2): row_byte = glyph[39:32];
      ROW_W'(3): row_byte = glyph[31:24];
      ROW_W'(4): row_byte = glyph[23:16];
      ROW_W'(5): row_byte = glyph[15:8];
      ROW_W'(6): row_byte = glyph[7:0];
      default:   row_byte = 8'h00;
    endcase
  end

  // Column c takes bit GLYPH_COLUMNS-1-c of the row byte.
  assign row_wide = {8'h00, row_byte};
  assign bits     = row_wide[GLYPH_COLUMNS-1:0];

endmodule : ftr_glyph_rom
`default_nettype wire

@@ hdl/font_text_rasterizer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// font_text_rasterizer - 5x7 font text to pixel-write converter
// Draws one character per input beat into a byte-per-pixel frame store by
// emitting one address/color beat for every lit, on-screen glyph pixel.
// ----------------------------------------------------------------------------
// One input beat is one character. With string_start set, the origin loads
// the pen and the line start first. A newline returns the pen to the line
// start and moves it 8 rows down; it emits nothing. Any other character is
// scanned row by row, top to bottom, left to right: each glyph row starts
// with a fetch step that reads the font bits and forms the row base address
// with the single 12x12 multiplier ((pen y + row) * line_pitch), then takes
// a column step per column up to the last lit column of that row. Rows that
// are blank or off screen get only their fetch step. One pixel is held back
// so the final beat of a character can carry last_of_char, which adds a
// closing step. The column and closing steps can hold while the result side
// stalls. The block takes no new character until the current one is fully
// issued; a finished beat sits in the output register while scanning
// continues. Configuration writes are taken at any time and apply from the
// next beat; write them only while the block is idle.
// ----------------------------------------------------------------------------
module font_text_rasterizer (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // character input
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire ftr_pkg::ftr_in_t                in_data,
  // pixel-write output
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output ftr_pkg::ftr_out_t                    out_data,
  // register writes
  input  wire logic                            cfg_we,
  input  wire logic [ftr_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [ftr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import ftr_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ROW   = 2'd1;
  localparam logic [1:0] S_COL   = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  // Configuration registers
  logic [11:0] width_r, height_r, pitch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 12'd640;
      height_r <= 12'd480;
      pitch_r  <= 12'd640;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_SCREEN_WIDTH:  width_r  <= cfg_wdata;
        CFG_SCREEN_HEIGHT: height_r <= cfg_wdata;
        CFG_LINE_PITCH:    pitch_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sequencer and datapath state
  logic [1:0]               state_r, state_nxt;
  logic signed [15:0]       pen_x_r, pen_x_nxt;
  logic signed [15:0]       pen_y_r, pen_y_nxt;
  logic signed [15:0]       line_x_r, line_x_nxt;
  logic [7:0]               code_r, code_nxt;
  logic [7:0]               color_r, color_nxt;
  logic [ROW_W-1:0]         row_r, row_nxt;
  logic [COL_W-1:0]         col_r, col_nxt;
  logic [GLYPH_COLUMNS-1:0] bits_r, bits_nxt;
  logic [21:0]              base_r, base_nxt;
  logic                     pend_vld_r, pend_vld_nxt;
  logic [21:0]              pend_addr_r, pend_addr_nxt;
  logic                     out_vld_r, out_vld_nxt;
  ftr_out_t                 out_r, out_nxt;

  // Input-side pen selection: origin on string start, else current pen
  logic signed [15:0] cur_x, cur_y, cur_line;
  logic [7:0]         folded;
  logic [16:0]        nl_sum;
  logic signed [15:0] nl_y;

  assign cur_line = in_data.string_start ? in_data.origin_x : line_x_r;
  assign cur_x    = in_data.string_start ? in_data.origin_x : pen_x_r;
  assign cur_y    = in_data.string_start ? in_data.origin_y : pen_y_r;

  always_comb begin
    folded = in_data.char_code;
    if (in_data.char_code inside {[8'h61:8'h7A]}) begin
      folded = in_data.char_code - 8'h20;
    end
  end

  // Newline step; the advance is positive so only the top limit can hit
  assign nl_sum = {cur_y[15], cur_y} + 17'(ADVANCE_Y);
  assign nl_y   = (nl_sum[16] != nl_sum[15]) ? 16'sh7FFF : nl_sum[15:0];

  // Pen advance at end of character
  logic [16:0]        adv_sum;
  logic signed [15:0] adv_x;

  assign adv_sum = {pen_x_r[15], pen_x_r} + 17'(ADVANCE_X);
  assign adv_x   = (adv_sum[16] != adv_sum[15]) ? 16'sh7FFF : adv_sum[15:0];

  // Font row fetch
  logic [GLYPH_COLUMNS-1:0] rom_bits;

  ftr_glyph_rom u_rom (
    .code (code_r),
    .row  (row_r),
    .bits (rom_bits)
  );

  // Row check and row base: the single multiplier
  logic [16:0] py_sum;
  logic        row_vis;
  logic [23:0] row_prod;

  assign py_sum   = {pen_y_r[15], pen_y_r} + {{(17-ROW_W){1'b0}}, row_r};
  assign row_vis  = !py_sum[16] && (py_sum[15:0] < {4'h0, height_r});
  assign row_prod = 24'(py_sum[11:0]) * 24'(pitch_r);

  // Column check and pixel address
  logic [16:0]              px_sum;
  logic                     hit;
  logic [21:0]              pix_addr;
  logic [GLYPH_COLUMNS-1:0] bits_sh;

  assign px_sum   = {pen_x_r[15], pen_x_r} + {{(17-COL_W){1'b0}}, col_r};
  assign hit      = bits_r[GLYPH_COLUMNS-1] && !px_sum[16]
                    && (px_sum[15:0] < {4'h0, width_r});
  assign pix_addr = base_r + {10'h000, px_sum[11:0]};
  assign bits_sh  = bits_r << 1;

  logic out_busy;
  logic push, push_last;
  logic row_end;

  assign out_busy = out_vld_r && !out_ready;
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    pen_x_nxt     = pen_x_r;
    pen_y_nxt     = pen_y_r;
    line_x_nxt    = line_x_r;
    code_nxt      = code_r;
    color_nxt     = color_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    bits_nxt      = bits_r;
    base_nxt      = base_r;
    pend_vld_nxt  = pend_vld_r;
    pend_addr_nxt = pend_addr_r;
    push          = 1'b0;
    push_last     = 1'b0;
    row_end       = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          line_x_nxt = cur_line;
          if (in_data.char_code == CHAR_NEWLINE) begin
            pen_x_nxt = cur_line;
            pen_y_nxt = nl_y;
          end else begin
            pen_x_nxt = cur_x;
            pen_y_nxt = cur_y;
            code_nxt  = folded;
            color_nxt = in_data.ink_color;
            row_nxt   = '0;
            state_nxt = S_ROW;
          end
        end
      end
      S_ROW: begin
        // Skip rows that are blank or off screen
        if (row_vis && (rom_bits != '0)) begin
          bits_nxt  = rom_bits;
          base_nxt  = row_prod[21:0];
          col_nxt   = '0;
          state_nxt = S_COL;
        end else begin
          row_end = 1'b1;
        end
      end
      S_COL: begin
        // Hold when a new pixel would displace the held one into a full output
        if (!(hit && pend_vld_r && out_busy)) begin
          if (hit) begin
            push          = pend_vld_r;
            pend_vld_nxt  = 1'b1;
            pend_addr_nxt = pix_addr;
          end
          bits_nxt = bits_sh;
          col_nxt  = col_r + COL_W'(1);
          if ((col_r == COL_W'(GLYPH_COLUMNS-1)) || (bits_sh == '0)) begin
            row_end = 1'b1;
          end
        end
      end
      S_FLUSH: begin
        if (!out_busy) begin
          push         = 1'b1;
          push_last    = 1'b1;
          pend_vld_nxt = 1'b0;
          pen_x_nxt    = adv_x;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // Advance to the next row, or close the character
    if (row_end) begin
      if (row_r == ROW_W'(GLYPH_ROWS-1)) begin
        if (pend_vld_nxt) begin
          state_nxt = S_FLUSH;
        end else begin
          pen_x_nxt = adv_x;
          state_nxt = S_IDLE;
        end
      end else begin
        row_nxt   = row_r + ROW_W'(1);
        state_nxt = S_ROW;
      end
    end
  end

  // Output register: load the held pixel, drop the beat once taken
  always_comb begin
    out_nxt     = out_r;
    out_vld_nxt = out_vld_r && !out_ready;
    if (push) begin
      out_nxt.pixel_address = pend_addr_r;
      out_nxt.pixel_color   = color_r;
      out_nxt.last_of_char  = push_last;
      out_vld_nxt           = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      pen_x_r    <= '0;
      pen_y_r    <= '0;
      line_x_r   <= '0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      pen_x_r    <= pen_x_nxt;
      pen_y_r    <= pen_y_nxt;
      line_x_r   <= line_x_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r      <= code_nxt;
    color_r     <= color_nxt;
    row_r       <= row_nxt;
    col_r       <= col_nxt;
    bits_r      <= bits_nxt;
    base_r      <= base_nxt;
    pend_addr_r <= pend_addr_nxt;
    out_r       <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule : font_text_rasterizer
`default_nettype wire
